@@ src/msblit_pkg.sv @@
// Shared types, codes and constants of the masked sprite blitter.
package msblit_pkg;

    localparam int WORD_BITS = 16;

    typedef logic [WORD_BITS-1:0] word_t;

    localparam word_t WORD_ONES = 16'b1111_1111_1111_1111;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_DRAW  = 2'd2,
        ACT_READ  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DRAW,
        ST_DRAIN,
        ST_CLEAR,
        ST_READ,
        ST_DONE
    } state_t;

    typedef struct packed {
        word_t color;
        word_t alpha;
    } sprite_entry_t;

endpackage

@@ src/msblit_cmd_if.sv @@
// Command channel: valid, ready and the command word fields.
interface msblit_cmd_if;
    import msblit_pkg::*;

    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [3:0] sprite_slot;
    logic [5:0] sprite_word;
    word_t      color_word;
    word_t      alpha_word;
    logic [7:0] pos_x;
    logic [6:0] pos_y;
    logic       background;
    logic [10:0] fb_address;

    modport source (
        output valid, action, sprite_slot, sprite_word, color_word, alpha_word,
               pos_x, pos_y, background, fb_address,
        input  ready
    );

    modport sink (
        input  valid, action, sprite_slot, sprite_word, color_word, alpha_word,
               pos_x, pos_y, background, fb_address,
        output ready
    );
endinterface

@@ src/msblit_rsp_if.sv @@
// Result channel: valid, ready and the result word fields.
interface msblit_rsp_if;
    import msblit_pkg::*;

    logic  valid;
    logic  ready;
    word_t read_data;
    logic  clipped;

    modport source (
        output valid, read_data, clipped,
        input  ready
    );

    modport sink (
        input  valid, read_data, clipped,
        output ready
    );
endinterface

@@ src/msblit_sprite_ram.sv @@
// Sprite store: color and alpha words, one write and one registered read port.
module msblit_sprite_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                          clk,
    input  logic                          we,
    input  logic [AW-1:0]                 waddr,
    input  msblit_pkg::sprite_entry_t     wdata,
    input  logic [AW-1:0]                 raddr,
    output msblit_pkg::sprite_entry_t     rdata
);
    import msblit_pkg::*;

    sprite_entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ src/msblit_frame_ram.sv @@
// Frame store: one write and one registered read port.
module msblit_frame_ram #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  msblit_pkg::word_t wdata,
    input  logic [AW-1:0]     raddr,
    output msblit_pkg::word_t rdata
);
    import msblit_pkg::*;

    word_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ src/masked_sprite_blitter_1bpp_core.sv @@
// Top level: command sequencer and frame merge pipeline of the sprite blitter.
//
// Usage:
//   cmd is the command channel, rsp the result channel; a word moves when
//   valid and ready are both high. Every command gives exactly one result word.
//   Commands are taken one at a time; cmd.ready is high only while idle, and a
//   new command is taken while the previous result still waits in the rsp
//   output register.
//   Work from accept to result valid:
//     load sprite word: one sprite write, if slot and word are in range
//     read frame word: one frame read; zero for an out-of-range address
//     clear frame: all FB_WORDS words, one frame word written a cycle
//     draw: SPRITE_ROWS * (SPRITE_WORDS_X, plus one if pos_x is not a multiple
//       of 16) frame words; each frame word is read and merged back once, with
//       the two halves of neighboring sprite words merged in the same pass.
//   A draw with an out-of-range slot returns at once with clipped low.
//   Reset clears only the sequencer, its counters and the valid flags; sprite
//   and frame stay undefined until written, so clear the frame before drawing.
//   When the receiver stalls, the result holds in the output register and the
//   block finishes the next command up to its result, then waits.
module masked_sprite_blitter_1bpp_core #(
    parameter int SPRITE_SLOTS   = 16,
    parameter int SPRITE_WORDS_X = 2,
    parameter int SPRITE_ROWS    = 32,
    parameter int FB_WORDS_X     = 16,
    parameter int FB_WORDS       = 2048
) (
    input  logic         clk,
    input  logic         rst_n,
    msblit_cmd_if.sink   cmd,
    msblit_rsp_if.source rsp
);
    import msblit_pkg::*;

    localparam int WPS       = SPRITE_WORDS_X * SPRITE_ROWS;
    localparam int SP_DEPTH  = SPRITE_SLOTS * WPS;
    localparam int SP_AW     = (SP_DEPTH > 1) ? $clog2(SP_DEPTH) : 1;
    localparam int FB_AW     = $clog2(FB_WORDS);
    localparam int MAX_FADDR = (127 + SPRITE_ROWS - 1) * FB_WORDS_X + 15 + SPRITE_WORDS_X;
    localparam int FA_W      = $clog2(MAX_FADDR + 1);
    localparam int K_W       = $clog2(SPRITE_WORDS_X + 2);
    localparam int R_W       = $clog2(SPRITE_ROWS + 1);
    localparam int COL_W     = $clog2(16 + SPRITE_WORDS_X + 1);

    state_t state_reg, state_next;

    logic              cmd_fire;
    logic              slot_ok;
    logic              load_ok;
    logic              read_ok;
    logic              rsp_load;

    logic [3:0]        shift_reg;
    logic [3:0]        col0_reg;
    logic [K_W-1:0]    k_reg;
    logic [R_W-1:0]    r_reg;
    logic [SP_AW-1:0]  sp_addr_reg;
    logic [FA_W-1:0]   row_base_reg;
    logic              clip_reg;
    logic              fill_reg;
    logic [FB_AW-1:0]  clr_addr_reg;
    logic              rd_ok_reg;
    word_t             res_data_reg;

    logic              s1_valid_reg;
    logic              s1_first_reg;
    logic              s1_has_cur_reg;
    logic              s1_write_reg;
    logic [FB_AW-1:0]  s1_addr_reg;
    word_t             prev_color_reg;
    word_t             prev_alpha_reg;

    logic              rsp_valid_reg;
    word_t             rsp_data_reg;
    logic              rsp_clip_reg;

    logic              issue;
    logic              has_cur;
    logic [K_W-1:0]    k_last;
    logic              row_end;
    logic              draw_end;
    logic [COL_W-1:0]  col;
    logic [FA_W-1:0]   faddr;
    logic              clip_word;

    logic              sp_we;
    logic [SP_AW-1:0]  sp_waddr;
    sprite_entry_t     sp_wdata;
    sprite_entry_t     sp_rdata;
    logic              fb_we;
    logic [FB_AW-1:0]  fb_waddr;
    word_t             fb_wdata;
    logic [FB_AW-1:0]  fb_raddr;
    word_t             fb_rdata;

    word_t             cur_color;
    word_t             cur_alpha;
    word_t             prv_color;
    word_t             prv_alpha;
    word_t             mrg_color;
    word_t             mrg_alpha;
    logic [4:0]        lshift;

    msblit_sprite_ram #(
        .DEPTH (SP_DEPTH),
        .AW    (SP_AW)
    ) u_sprite_ram (
        .clk   (clk),
        .we    (sp_we),
        .waddr (sp_waddr),
        .wdata (sp_wdata),
        .raddr (sp_addr_reg),
        .rdata (sp_rdata)
    );

    msblit_frame_ram #(
        .DEPTH (FB_WORDS),
        .AW    (FB_AW)
    ) u_frame_ram (
        .clk   (clk),
        .we    (fb_we),
        .waddr (fb_waddr),
        .wdata (fb_wdata),
        .raddr (fb_raddr),
        .rdata (fb_rdata)
    );

    assign cmd_fire = cmd.valid && cmd.ready;
    assign slot_ok  = 32'(cmd.sprite_slot) < SPRITE_SLOTS;
    assign load_ok  = slot_ok && (32'(cmd.sprite_word) < WPS);
    assign read_ok  = 32'(cmd.fb_address) < FB_WORDS;
    assign rsp_load = (state_reg == ST_DONE) && (!rsp_valid_reg || rsp.ready);

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.read_data = rsp_data_reg;
    assign rsp.clipped   = rsp_clip_reg;

    // draw step address generation
    always_comb
    begin
        has_cur   = 32'(k_reg) < SPRITE_WORDS_X;
        k_last    = (shift_reg == 4'd0) ? K_W'(SPRITE_WORDS_X - 1) : K_W'(SPRITE_WORDS_X);
        row_end   = (k_reg == k_last);
        draw_end  = row_end && (32'(r_reg) == SPRITE_ROWS - 1);
        col       = COL_W'(col0_reg) + COL_W'(k_reg);
        faddr     = row_base_reg + FA_W'(col);
        clip_word = (32'(col) >= FB_WORDS_X) || (32'(faddr) >= FB_WORDS);
    end

    // merge of the shifted sprite halves into one frame word
    always_comb
    begin
        cur_color = s1_has_cur_reg ? sp_rdata.color : '0;
        cur_alpha = s1_has_cur_reg ? sp_rdata.alpha : '0;
        prv_color = s1_first_reg ? '0 : prev_color_reg;
        prv_alpha = s1_first_reg ? '0 : prev_alpha_reg;
        lshift    = 5'(WORD_BITS) - {1'b0, shift_reg};
        if (shift_reg == 4'd0)
        begin
            mrg_color = cur_color;
            mrg_alpha = cur_alpha;
        end
        else
        begin
            mrg_color = (prv_color << lshift) | (cur_color >> shift_reg);
            mrg_alpha = (prv_alpha << lshift) | (cur_alpha >> shift_reg);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    unique case (action_t'(cmd.action))
                        ACT_LOAD:  state_next = ST_DONE;
                        ACT_CLEAR: state_next = ST_CLEAR;
                        ACT_DRAW:  state_next = slot_ok ? ST_DRAW : ST_DONE;
                        ACT_READ:  state_next = ST_READ;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_DRAW:
            begin
                if (draw_end)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_DONE;
            ST_CLEAR:
            begin
                if (32'(clr_addr_reg) == FB_WORDS - 1)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_READ:  state_next = ST_DONE;
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.ready      = 1'b0;
        issue          = 1'b0;
        sp_we          = 1'b0;
        sp_waddr       = SP_AW'(32'(cmd.sprite_slot) * WPS + 32'(cmd.sprite_word));
        sp_wdata.color = cmd.color_word;
        sp_wdata.alpha = cmd.alpha_word;
        fb_raddr       = FB_AW'(cmd.fb_address);
        fb_we          = s1_valid_reg && s1_write_reg;
        fb_waddr       = s1_addr_reg;
        fb_wdata       = (mrg_color & mrg_alpha) | (fb_rdata & ~mrg_alpha);
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.ready = 1'b1;
                sp_we     = cmd.valid && (action_t'(cmd.action) == ACT_LOAD) && load_ok;
            end
            ST_DRAW:
            begin
                issue    = 1'b1;
                fb_raddr = FB_AW'(faddr);
            end
            ST_CLEAR:
            begin
                fb_we    = 1'b1;
                fb_waddr = clr_addr_reg;
                fb_wdata = fill_reg ? WORD_ONES : '0;
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            k_reg         <= '0;
            r_reg         <= '0;
            clr_addr_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            s1_valid_reg <= issue;
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (cmd_fire)
            begin
                k_reg        <= '0;
                r_reg        <= '0;
                clr_addr_reg <= '0;
            end
            else if (issue)
            begin
                if (row_end)
                begin
                    k_reg <= '0;
                    r_reg <= r_reg + R_W'(1);
                end
                else
                begin
                    k_reg <= k_reg + K_W'(1);
                end
            end
            else if (state_reg == ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + FB_AW'(1);
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            shift_reg    <= cmd.pos_x[3:0];
            col0_reg     <= cmd.pos_x[7:4];
            sp_addr_reg  <= SP_AW'(32'(cmd.sprite_slot) * WPS);
            row_base_reg <= FA_W'(32'(cmd.pos_y) * FB_WORDS_X);
            fill_reg     <= cmd.background;
            rd_ok_reg    <= read_ok;
            clip_reg     <= 1'b0;
            res_data_reg <= '0;
        end
        if (issue)
        begin
            s1_first_reg   <= (k_reg == '0);
            s1_has_cur_reg <= has_cur;
            s1_write_reg   <= !clip_word;
            s1_addr_reg    <= FB_AW'(faddr);
            clip_reg       <= clip_reg | clip_word;
            if (has_cur)
            begin
                sp_addr_reg <= sp_addr_reg + SP_AW'(1);
            end
            if (row_end)
            begin
                row_base_reg <= row_base_reg + FA_W'(FB_WORDS_X);
            end
        end
        if (s1_valid_reg)
        begin
            prev_color_reg <= cur_color;
            prev_alpha_reg <= cur_alpha;
        end
        if (state_reg == ST_READ)
        begin
            res_data_reg <= rd_ok_reg ? fb_rdata : '0;
        end
        if (rsp_load)
        begin
            rsp_data_reg <= res_data_reg;
            rsp_clip_reg <= clip_reg;
        end
    end
endmodule

@@ dv/masked_sprite_blitter_1bpp_core_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the sprite blitter: command driver, result monitor, predictor.
module masked_sprite_blitter_1bpp_core_tb;
    import msblit_pkg::*;

    localparam int SPRITE_SLOTS     = 16;
    localparam int SPRITE_WORDS_X   = 2;
    localparam int SPRITE_ROWS      = 32;
    localparam int FB_WORDS_X       = 16;
    localparam int FB_WORDS         = 2048;
    localparam int WORDS_PER_SPRITE = SPRITE_WORDS_X * SPRITE_ROWS;
    localparam int SPRITE_DEPTH     = SPRITE_SLOTS * WORDS_PER_SPRITE;
    localparam int RANDOM_ITEMS     = 1100;
    localparam int WATCHDOG_CYCLES  = 20000;
    localparam int TAIL_CYCLES      = 120;
    localparam int MAX_REPORTS      = 30;

    typedef struct {
        action_t     act;
        logic [3:0]  slot;
        logic [5:0]  sword;
        word_t       color;
        word_t       alpha;
        logic [7:0]  pos_x;
        logic [6:0]  pos_y;
        logic        background;
        logic [10:0] fb_address;
        logic        drain_first;
    } blit_cmd_t;

    typedef struct {
        action_t act;
        word_t   read_data;
        logic    clipped;
    } blit_result_t;

    logic clk;
    logic rst_n;

    msblit_cmd_if cmd_ch ();
    msblit_rsp_if rsp_ch ();

    masked_sprite_blitter_1bpp_core #(
        .SPRITE_SLOTS   (SPRITE_SLOTS),
        .SPRITE_WORDS_X (SPRITE_WORDS_X),
        .SPRITE_ROWS    (SPRITE_ROWS),
        .FB_WORDS_X     (FB_WORDS_X),
        .FB_WORDS       (FB_WORDS)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    word_t frame_mirror  [FB_WORDS];
    word_t color_mirror  [SPRITE_DEPTH];
    word_t alpha_mirror  [SPRITE_DEPTH];

    blit_cmd_t    pending_cmds [$];
    blit_result_t expected_results [$];

    logic [WORDS_PER_SPRITE-1:0] slot_filled [SPRITE_SLOTS];
    logic frame_valid;
    logic hold_next;
    int   last_draw_x;
    int   last_draw_y;

    int cmds_queued;
    int cmd_presented;
    int cmd_accepted;
    int results_checked;
    int error_count;
    int idle_cycles;
    int burst_left;
    int gap_left;
    int ready_mode;
    int ready_phase;
    logic [15:0] stall_pattern;
    int action_count [4];
    int clipped_draws;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic merge_word(input int row, input int col, input word_t color,
                                        input word_t alpha);
        int addr;
        if (col >= FB_WORDS_X)
            return 1'b1;
        addr = row * FB_WORDS_X + col;
        if (addr >= FB_WORDS)
            return 1'b1;
        frame_mirror[addr] = (color & alpha) | (frame_mirror[addr] & ~alpha);
        return 1'b0;
    endfunction

    function automatic blit_result_t predict_blit(input blit_cmd_t c);
        blit_result_t res;
        int idx;
        int bit_shift;
        int col0;
        int row;
        int col;
        word_t sc;
        word_t sa;
        word_t part_c;
        word_t part_a;
        res.act       = c.act;
        res.read_data = '0;
        res.clipped   = 1'b0;
        case (c.act)
            ACT_LOAD:
            begin
                if (c.slot < SPRITE_SLOTS && c.sword < WORDS_PER_SPRITE)
                begin
                    idx = c.slot * WORDS_PER_SPRITE + c.sword;
                    color_mirror[idx] = c.color;
                    alpha_mirror[idx] = c.alpha;
                end
            end
            ACT_CLEAR:
            begin
                for (int i = 0; i < FB_WORDS; i++)
                    frame_mirror[i] = c.background ? WORD_ONES : '0;
            end
            ACT_DRAW:
            begin
                if (c.slot < SPRITE_SLOTS)
                begin
                    bit_shift = c.pos_x % WORD_BITS;
                    col0 = c.pos_x / WORD_BITS;
                    for (int r = 0; r < SPRITE_ROWS; r++)
                    begin
                        for (int k = 0; k < SPRITE_WORDS_X; k++)
                        begin
                            idx = c.slot * WORDS_PER_SPRITE + r * SPRITE_WORDS_X + k;
                            sc  = color_mirror[idx];
                            sa  = alpha_mirror[idx];
                            row = r + c.pos_y;
                            col = k + col0;
                            if (bit_shift == 0)
                            begin
                                if (merge_word(row, col, sc, sa))
                                    res.clipped = 1'b1;
                            end
                            else
                            begin
                                part_c = sc >> bit_shift;
                                part_a = sa >> bit_shift;
                                if (merge_word(row, col, part_c, part_a))
                                    res.clipped = 1'b1;
                                part_c = sc << (WORD_BITS - bit_shift);
                                part_a = sa << (WORD_BITS - bit_shift);
                                if (merge_word(row, col + 1, part_c, part_a))
                                    res.clipped = 1'b1;
                            end
                        end
                    end
                end
            end
            default:
            begin
                if (c.fb_address < FB_WORDS)
                    res.read_data = frame_mirror[c.fb_address];
            end
        endcase
        return res;
    endfunction

    function automatic blit_cmd_t fresh_cmd(input action_t a);
        blit_cmd_t c;
        c.act         = a;
        c.slot        = 4'($urandom);
        c.sword       = 6'($urandom);
        c.color       = word_t'($urandom);
        c.alpha       = word_t'($urandom);
        c.pos_x       = 8'($urandom);
        c.pos_y       = 7'($urandom);
        c.background  = 1'($urandom);
        c.fb_address  = 11'($urandom);
        c.drain_first = 1'b0;
        return c;
    endfunction

    function automatic word_t pick_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return WORD_ONES;
            2: return word_t'(1) << $urandom_range(0, WORD_BITS - 1);
            3: return ~(word_t'(1) << $urandom_range(0, WORD_BITS - 1));
            default: return word_t'($urandom);
        endcase
    endfunction

    function automatic int pick_full_slot();
        int s;
        s = $urandom_range(0, SPRITE_SLOTS - 1);
        for (int k = 0; k < SPRITE_SLOTS; k++)
        begin
            if (&slot_filled[(s + k) % SPRITE_SLOTS])
                return (s + k) % SPRITE_SLOTS;
        end
        return -1;
    endfunction

    task automatic enqueue_cmd(input blit_cmd_t c);
        c.drain_first = hold_next;
        hold_next = 1'b0;
        if (c.act == ACT_LOAD)
            slot_filled[c.slot][c.sword] = 1'b1;
        if (c.act == ACT_CLEAR)
            frame_valid = 1'b1;
        pending_cmds.push_back(c);
        cmds_queued++;
    endtask

    task automatic add_load(input int slot, input int sword, input word_t color,
                            input word_t alpha);
        blit_cmd_t c;
        c = fresh_cmd(ACT_LOAD);
        c.slot  = 4'(slot);
        c.sword = 6'(sword);
        c.color = color;
        c.alpha = alpha;
        enqueue_cmd(c);
    endtask

    task automatic add_clear(input logic bg);
        blit_cmd_t c;
        c = fresh_cmd(ACT_CLEAR);
        c.background = bg;
        enqueue_cmd(c);
    endtask

    task automatic add_draw(input int slot, input int x, input int y);
        blit_cmd_t c;
        c = fresh_cmd(ACT_DRAW);
        c.slot  = 4'(slot);
        c.pos_x = 8'(x);
        c.pos_y = 7'(y);
        last_draw_x = x;
        last_draw_y = y;
        enqueue_cmd(c);
    endtask

    task automatic add_read(input int addr);
        blit_cmd_t c;
        c = fresh_cmd(ACT_READ);
        c.fb_address = 11'(addr);
        enqueue_cmd(c);
    endtask

    task automatic queue_sprite(input int slot, input int style);
        word_t a;
        int w;
        logic reverse;
        reverse = 1'($urandom_range(0, 1));
        for (int i = 0; i < WORDS_PER_SPRITE; i++)
        begin
            w = reverse ? WORDS_PER_SPRITE - 1 - i : i;
            case (style)
                0: a = word_t'($urandom);
                1: a = WORD_ONES;
                2: a = '0;
                default: a = word_t'($urandom & $urandom);
            endcase
            add_load(slot, w, word_t'($urandom), a);
        end
    endtask

    task automatic note_mismatch(input string what, input word_t want, input word_t got);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%0t: %s expected %h, got %h", $time, what, want, got);
    endtask

    // command driver
    always @(negedge clk)
    begin
        blit_cmd_t nxt;
        if (rst_n && !(cmd_ch.valid && cmd_accepted != cmd_presented))
        begin
            if (gap_left != 0)
            begin
                gap_left--;
                cmd_ch.valid <= 1'b0;
            end
            else if (pending_cmds.size() != 0 &&
                     (!pending_cmds[0].drain_first || expected_results.size() == 0))
            begin
                nxt = pending_cmds.pop_front();
                cmd_ch.action      <= nxt.act;
                cmd_ch.sprite_slot <= nxt.slot;
                cmd_ch.sprite_word <= nxt.sword;
                cmd_ch.color_word  <= nxt.color;
                cmd_ch.alpha_word  <= nxt.alpha;
                cmd_ch.pos_x       <= nxt.pos_x;
                cmd_ch.pos_y       <= nxt.pos_y;
                cmd_ch.background  <= nxt.background;
                cmd_ch.fb_address  <= nxt.fb_address;
                cmd_ch.valid       <= 1'b1;
                cmd_presented++;
                if (burst_left == 0)
                begin
                    if ($urandom_range(0, 3) == 0)
                    begin
                        burst_left = $urandom_range(30, 80);
                        gap_left   = 0;
                    end
                    else
                    begin
                        burst_left = $urandom_range(0, 12);
                        gap_left   = $urandom_range(0, 4) == 0 ? $urandom_range(8, 24)
                                                               : $urandom_range(0, 5);
                    end
                end
                else
                    burst_left--;
            end
            else
                cmd_ch.valid <= 1'b0;
        end
    end

    // result receiver stalls
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (ready_phase == 0)
            begin
                ready_mode    = $urandom_range(0, 2);
                ready_phase   = $urandom_range(50, 400);
                stall_pattern = 16'($urandom) | 16'h0001;
            end
            else
                ready_phase--;
            stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
            case (ready_mode)
                0: rsp_ch.ready <= 1'b1;
                1: rsp_ch.ready <= $urandom_range(0, 3) != 0;
                default: rsp_ch.ready <= stall_pattern[0];
            endcase
        end
    end

    // monitor and checker
    always @(posedge clk)
    begin
        blit_cmd_t seen;
        blit_result_t want;
        if (rst_n)
        begin
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                seen.act         = action_t'(cmd_ch.action);
                seen.slot        = cmd_ch.sprite_slot;
                seen.sword       = cmd_ch.sprite_word;
                seen.color       = cmd_ch.color_word;
                seen.alpha       = cmd_ch.alpha_word;
                seen.pos_x       = cmd_ch.pos_x;
                seen.pos_y       = cmd_ch.pos_y;
                seen.background  = cmd_ch.background;
                seen.fb_address  = cmd_ch.fb_address;
                seen.drain_first = 1'b0;
                want = predict_blit(seen);
                expected_results.push_back(want);
                action_count[seen.act]++;
                if (want.act == ACT_DRAW && want.clipped)
                    clipped_draws++;
                cmd_accepted++;
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                results_checked++;
                if (expected_results.size() == 0)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: result with none expected, read_data %h clipped %b",
                                 $time, rsp_ch.read_data, rsp_ch.clipped);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (rsp_ch.read_data !== want.read_data)
                        note_mismatch({want.act.name(), " read_data"}, want.read_data,
                                      rsp_ch.read_data);
                    if (rsp_ch.clipped !== want.clipped)
                        note_mismatch({want.act.name(), " clipped"}, word_t'(want.clipped),
                                      word_t'(rsp_ch.clipped));
                end
            end
            if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_CYCLES)
            begin
                $display("%0t: no progress for %0d cycles", $time, WATCHDOG_CYCLES);
                $display("masked_sprite_blitter_1bpp_core_tb NOT OK");
                $finish;
            end
        end
    end

    initial
    begin
        int kind;
        int s;
        int random_start;
        rst_n = 1'b0;
        cmd_ch.valid       = 1'b0;
        cmd_ch.action      = ACT_LOAD;
        cmd_ch.sprite_slot = '0;
        cmd_ch.sprite_word = '0;
        cmd_ch.color_word  = '0;
        cmd_ch.alpha_word  = '0;
        cmd_ch.pos_x       = '0;
        cmd_ch.pos_y       = '0;
        cmd_ch.background  = 1'b0;
        cmd_ch.fb_address  = '0;
        rsp_ch.ready       = 1'b0;
        frame_valid = 1'b0;
        hold_next   = 1'b0;
        last_draw_x = 0;
        last_draw_y = 0;
        cmds_queued = 0;
        cmd_presented = 0;
        cmd_accepted = 0;
        results_checked = 0;
        error_count = 0;
        idle_cycles = 0;
        burst_left = 0;
        gap_left = 0;
        ready_mode = 0;
        ready_phase = 0;
        stall_pattern = 16'h0001;
        clipped_draws = 0;
        for (int i = 0; i < 4; i++)
            action_count[i] = 0;
        for (int i = 0; i < SPRITE_SLOTS; i++)
            slot_filled[i] = '0;
        for (int i = 0; i < FB_WORDS; i++)
            frame_mirror[i] = '0;
        for (int i = 0; i < SPRITE_DEPTH; i++)
        begin
            color_mirror[i] = '0;
            alpha_mirror[i] = '0;
        end

        add_clear(1'b1);
        add_read(0);
        add_read(FB_WORDS - 1);
        queue_sprite(0, 0);
        queue_sprite(SPRITE_SLOTS - 1, 3);
        add_load(0, 0, '0, WORD_ONES);
        add_load(SPRITE_SLOTS - 1, WORDS_PER_SPRITE - 1, WORD_ONES, WORD_ONES);
        add_load(SPRITE_SLOTS - 1, WORDS_PER_SPRITE - 2, WORD_ONES, '0);
        add_load(0, WORDS_PER_SPRITE - 1, '0, '0);
        add_draw(SPRITE_SLOTS - 1, 0, 0);
        add_read(0);
        add_read(1);
        add_draw(0, 255, 127);
        add_draw(0, 224, 96);
        add_read(FB_WORDS - 1);
        add_draw(SPRITE_SLOTS - 1, 225, 96);
        add_draw(0, 7, 97);
        add_draw(SPRITE_SLOTS - 1, 16, 40);
        add_read(40 * FB_WORDS_X + 1);
        add_draw(0, 0, 127);
        hold_next = 1'b1;
        add_clear(1'b0);
        add_read(1000);
        add_draw(SPRITE_SLOTS - 1, 100, 10);
        add_read(10 * FB_WORDS_X + 6);
        add_read(11 * FB_WORDS_X + 7);

        random_start = cmds_queued;
        while (cmds_queued < random_start + RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 99);
            if ($urandom_range(0, 99) == 0)
                hold_next = 1'b1;
            if (kind < 1)
                queue_sprite($urandom_range(0, SPRITE_SLOTS - 1), $urandom_range(0, 3));
            else if (kind < 30)
                add_load($urandom_range(0, SPRITE_SLOTS - 1),
                         $urandom_range(0, WORDS_PER_SPRITE - 1), pick_word(), pick_word());
            else if (kind < 32)
                add_clear(1'($urandom_range(0, 1)));
            else if (kind < 62)
            begin
                s = pick_full_slot();
                if (s >= 0 && frame_valid)
                begin
                    case ($urandom_range(0, 3))
                        0: add_draw(s, $urandom_range(0, 15) * WORD_BITS,
                                    $urandom_range(0, 127));
                        1: add_draw(s, $urandom_range(224, 255), $urandom_range(0, 127));
                        2: add_draw(s, $urandom_range(0, 223), $urandom_range(0, 96));
                        default: add_draw(s, $urandom_range(0, 255),
                                          $urandom_range(0, 3) == 0 ? $urandom_range(97, 127)
                                                                    : $urandom_range(0, 127));
                    endcase
                end
            end
            else if ($urandom_range(0, 2) != 0)
                add_read(((last_draw_y + $urandom_range(0, SPRITE_ROWS - 1)) % 128) * FB_WORDS_X
                         + ((last_draw_x / WORD_BITS + $urandom_range(0, SPRITE_WORDS_X))
                            % FB_WORDS_X));
            else
                add_read($urandom_range(0, FB_WORDS - 1));
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_cmds.size() != 0 || cmd_accepted != cmds_queued ||
               expected_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Ran %0d commands: %0d sprite loads, %0d clears, %0d draws, %0d reads",
                 cmd_accepted, action_count[ACT_LOAD], action_count[ACT_CLEAR],
                 action_count[ACT_DRAW], action_count[ACT_READ]);
        $display("Checked %0d result words; %0d draws were clipped at the frame edges",
                 results_checked, clipped_draws);
        if (error_count == 0)
            $display("masked_sprite_blitter_1bpp_core_tb OK");
        else
            $display("masked_sprite_blitter_1bpp_core_tb NOT OK");
        $finish;
    end
endmodule
